// ----- rtl/pks_pkg.sv -----
// Shared types and constants for the packed 12-bit sample store.
// Used by pks_cfg, pks_store and packed_12bit_sample_store_core; no dependencies.
package pks_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;

    localparam int CAP_W = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic FUNC_PUT = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_INDEX   = 2'd3;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic               func;
        logic               start_buffer;
        logic signed [15:0] sample_in;
        logic [9:0]         sample_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] sample_out;
        logic [10:0] count_out;
    } t_out_word;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic odd;
    } t_store_ctl;

endpackage

// ----- rtl/packed_12bit_sample_store_core.sv -----
// Packed 12-bit sample store, top level: handshake, count, status and sequencing.
// Depends on pks_pkg, pks_cfg and pks_store.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one word per item:
//   a put appends sample_in at the running count, a get reads back sample_index.
//   Output channel (o_out_valid / i_out_stall / o_out_word) returns one word per
//   item: status, the unpacked sample on a good get, and the count after the item.
//   Samples sit two per three bytes in one synchronous memory; a put reads the
//   pair word, merges its nibble and byte and writes the word back.
//   Timing: an accepted item reads memory as it is taken; in the execute step the
//   merged word is written and the result is loaded, which raises o_out_valid.
//   The next item is accepted only once the execute step has finished, as the
//   read and the write-back share one memory step per item.
//   The output register decouples the sides: a new item is taken while a result
//   still waits. If the receiver stalls, the result holds; a following item holds
//   in its execute step with its read data until the output register frees.
//   Reset clears the count and sets capacity to 1024; the memory is not cleared,
//   since a get only reaches pairs written since the last start of buffer.
//   The user writes capacity over the APB-style port only while the block is idle; not enforced.
module packed_12bit_sample_store_core
    import pks_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int VW    = (CW > CAP_W) ? CW : CAP_W;
    localparam int PAIRS = (MAX_SAMPLES + 1) / 2;
    localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam logic [VW-1:0] MAX_V = VW'(MAX_SAMPLES);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_func;
    logic [1:0]       r_status, n_status;
    logic             r_odd;
    logic [AW-1:0]    r_addr;
    logic [11:0]      r_sample;
    logic             r_out_valid;
    t_out_word        r_out;

    logic [CAP_W-1:0] capacity;
    logic [VW-1:0]    cap_use;
    logic [VW-1:0]    cnt_eff;
    logic [VW-1:0]    idx_ext;
    logic [VW-1:0]    pos;
    logic             in_accept;
    logic             out_free;
    logic             finish;
    logic [11:0]      store_sample;
    t_store_ctl       s_ctl;

    pks_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    // Accept only in idle; the execute step owns the memory until it finishes.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign finish     = (r_state == S_EXEC) && out_free;

    // Saturate capacity to the store size.
    assign cap_use = (VW'(capacity) > MAX_V) ? MAX_V : VW'(capacity);
    // Start of buffer clears the count before the checks, even if the put fails.
    assign cnt_eff = ((i_in_word.func == FUNC_PUT) && i_in_word.start_buffer)
                     ? '0 : VW'(r_count);
    assign idx_ext = VW'(i_in_word.sample_index);
    assign pos     = (i_in_word.func == FUNC_PUT) ? cnt_eff : idx_ext;

    // Decide status and next count at accept time: overrun first, then range.
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        if (in_accept) begin
            if (i_in_word.func == FUNC_PUT) begin
                n_count = CW'(cnt_eff);
                if (cnt_eff >= cap_use) begin
                    n_status = ST_OVERRUN;
                end else if (i_in_word.sample_in[15:12] != 4'd0) begin
                    n_status = ST_RANGE;
                end else begin
                    n_count = CW'(cnt_eff + VW'(1));
                end
            end else if (idx_ext >= VW'(r_count)) begin
                n_status = ST_INDEX;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Latch the item's decision and write data for the execute step.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func   <= i_in_word.func;
            r_status <= n_status;
            r_odd    <= pos[0];
            r_addr   <= pos[AW:1];
            r_sample <= i_in_word.sample_in[11:0];
        end
    end

    // Read the pair word only when the item will use it.
    assign s_ctl.rd_en = in_accept && (n_status == ST_OK);
    assign s_ctl.wr_en = finish && (r_func == FUNC_PUT) && (r_status == ST_OK);
    assign s_ctl.odd   = r_odd;

    pks_store #(
        .DEPTH (PAIRS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (s_ctl),
        .i_rd_addr (pos[AW:1]),
        .i_wr_addr (r_addr),
        .i_sample  (r_sample),
        .o_sample  (store_sample)
    );

    // Output register: load on finish, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out.status     <= r_status;
            r_out.sample_out <= ((r_func == FUNC_GET) && (r_status == ST_OK))
                                ? store_sample : 12'd0;
            r_out.count_out  <= 11'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // An accepted item always enters the execute step.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execute");

    // The stored count never passes the store size.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        VW'(r_count) <= MAX_V)
        else $error("sample count beyond store size");

    // Memory read and write never share a cycle; writes only in execute.
    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctl.wr_en |-> ((r_state == S_EXEC) && !s_ctl.rd_en))
        else $error("memory write outside execute or alongside a read");

    // The count moves only when an item is accepted.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_count))
        else $error("count changed without an accepted item");

endmodule

// ----- rtl/pks_cfg.sv -----
// APB-style configuration register for the packed sample store (capacity).
// Depends on pks_pkg.
module pks_cfg
    import pks_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [CAP_W-1:0] o_capacity
);

    logic [CAP_W-1:0] r_cap;
    logic             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (wr_hit) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata     = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, r_cap} : 32'd0;
    assign o_capacity = r_cap;

endmodule

// ----- rtl/pks_store.sv -----
// Byte-packed sample memory: three bytes per sample pair, read then merge and write back.
// Depends on pks_pkg.
module pks_store
    import pks_pkg::*;
#(
    parameter int DEPTH = (MAX_SAMPLES_DEF + 1) / 2,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  t_store_ctl    i_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [11:0]   i_sample,
    output logic [11:0]   o_sample
);

    // byte 0 in [7:0], byte 1 in [15:8], byte 2 in [23:16]
    logic [23:0] mem [DEPTH];
    logic [23:0] r_rdata;
    logic [23:0] n_word;

    // Even sample: low byte to byte 0, high nibble to upper half of byte 1.
    // Odd sample: high nibble ORed into byte 1, low byte to byte 2.
    always_comb begin
        if (i_ctl.odd) begin
            n_word = {i_sample[7:0], r_rdata[15:8] | {4'd0, i_sample[11:8]}, r_rdata[7:0]};
        end else begin
            n_word = {r_rdata[23:16], i_sample[11:8], 4'd0, i_sample[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= mem[i_rd_addr];
        end
    end

    assign o_sample = i_ctl.odd ? {r_rdata[11:8], r_rdata[23:16]}
                                : {r_rdata[15:12], r_rdata[7:0]};

endmodule
